>>> src/assert_macros.svh
// Assertion macros shared by the RTL of the min-tracking stack.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/mts_pkg.sv
// Package for the min-tracking stack: status and request-kind codes.
// No dependencies; used by min_tracking_stack.
package mts_pkg;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_EMPTY = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

endpackage

>>> src/min_tracking_stack.sv
// Top level of the min-tracking stack: datapath, stack memory and output register.
// Depends on mts_pkg and assert_macros.svh.

// A bounded stack of signed words that reports its minimum after every request. Each
// request on the slave side is a push or a pop, and each produces exactly one response
// on the master side carrying the popped value, the minimum after the step (all ones
// when the stack is empty), a status code and the occupancy. The block sustains one
// request per clock: a request is worked out in the cycle it is accepted and its
// response is registered into the output register, and s_tready stays high while
// that register is empty or being drained, so back-to-back requests flow without gaps.
// The rate is set by the single-port access to the stack memory: the top of stack and
// the entry beneath it live in registers, so a pop never waits on a memory read; the
// memory read for the entry two below the top is issued in the same cycle as the pop.
// Stored words are two bits wider than the values so that the minimum encoding (a push
// below the minimum stores twice the value less the old minimum) cannot overflow. The
// memory needs no clearing after reset; only entries that have been written are used.
`include "assert_macros.svh"

module min_tracking_stack #(
    parameter int DEPTH       = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // [0] action, [VALUE_WIDTH:1] push_value, zero padding above
    input  logic [((VALUE_WIDTH + 1 + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // popped_value, min_value, status, occupancy from the lowest bit up, zero padding above
    output logic [((2 * VALUE_WIDTH + 2 + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = VALUE_WIDTH + 2;
    localparam int VW    = VALUE_WIDTH;
    localparam int OUT_W = ((2 * VW + 2 + CW + 7) / 8) * 8;
    localparam int PAD_W = OUT_W - (2 * VW + 2 + CW);

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [CW-1:0] TWO_C   = CW'(2);
    localparam logic [CW-1:0] THREE_C = CW'(3);

    // Stack state. The top entry and the entry beneath it are held in registers; the
    // memory holds everything further down. The entry beneath the top is either in
    // under_reg or in the memory read register, as under_mem_reg says.
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic signed [VW-1:0]   min_reg, min_next;
    logic signed [SW-1:0]   top_reg, top_next;
    logic signed [SW-1:0]   under_reg;
    logic                   under_mem_reg;
    logic signed [SW-1:0]   rd_data_reg;
    logic signed [SW-1:0]   mem [DEPTH];

    logic                   m_tvalid_reg;
    logic [OUT_W-1:0]       m_tdata_reg;

    // Request decode.
    logic                   in_acc;
    logic                   action;
    logic signed [VW-1:0]   push_value;
    logic signed [SW-1:0]   x_ext;
    logic signed [SW-1:0]   min_ext;
    logic signed [SW-1:0]   under_val;
    logic signed [SW-1:0]   enc_val;
    logic signed [SW-1:0]   restore_val;
    logic [CW-1:0]          cnt_m2;
    logic [CW-1:0]          cnt_m3;
    logic                   do_push;
    logic                   do_pop;
    logic                   wr_en;
    logic                   rd_en;

    logic signed [VW-1:0]   popped_value;
    logic signed [VW-1:0]   min_value;
    mts_pkg::status_t       status;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;

    assign action     = s_tdata[0];
    assign push_value = s_tdata[VW:1];

    assign x_ext     = {{2{push_value[VW-1]}}, push_value};
    assign min_ext   = {{2{min_reg[VW-1]}}, min_reg};
    assign under_val = under_mem_reg ? rd_data_reg : under_reg;

    // Encoded word for a push below the minimum, and the minimum restored by a pop of an
    // encoded word. Neither can overflow the widened store word.
    assign enc_val     = (x_ext <<< 1) - min_ext;
    assign restore_val = (min_ext <<< 1) - top_reg;

    assign cnt_m2 = cnt_reg - TWO_C;
    assign cnt_m3 = cnt_reg - THREE_C;

    assign do_push = in_acc && (action == mts_pkg::ACT_PUSH) && (cnt_reg != DEPTH_C);
    assign do_pop  = in_acc && (action == mts_pkg::ACT_POP) && (cnt_reg != '0);

    // A push spills the entry beneath the top into memory once there is one to spill.
    assign wr_en = do_push && (cnt_reg >= TWO_C);
    // A pop fetches the entry that becomes the new one beneath the top.
    assign rd_en = do_pop;

    always_comb
    begin
        cnt_next     = cnt_reg;
        min_next     = min_reg;
        top_next     = top_reg;
        popped_value = '1;
        status       = mts_pkg::STATUS_OK;
        if (action == mts_pkg::ACT_PUSH)
        begin
            if (cnt_reg == DEPTH_C)
            begin
                status = mts_pkg::STATUS_FULL;
            end
            else if (cnt_reg == '0)
            begin
                min_next = push_value;
                top_next = x_ext;
                cnt_next = ONE_C;
            end
            else if (x_ext < min_ext)
            begin
                top_next = enc_val;
                min_next = push_value;
                cnt_next = cnt_reg + ONE_C;
            end
            else
            begin
                top_next = x_ext;
                cnt_next = cnt_reg + ONE_C;
            end
        end
        else
        begin
            if (cnt_reg == '0)
            begin
                status = mts_pkg::STATUS_EMPTY;
            end
            else
            begin
                if (top_reg >= min_ext)
                begin
                    popped_value = top_reg[VW-1:0];
                end
                else
                begin
                    popped_value = min_reg;
                    min_next     = restore_val[VW-1:0];
                end
                top_next = under_val;
                cnt_next = cnt_reg - ONE_C;
            end
        end
        min_value = (cnt_next == '0) ? '1 : min_next;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            min_reg       <= '0;
            under_mem_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                cnt_reg      <= cnt_next;
                min_reg      <= min_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (do_push)
            begin
                under_mem_reg <= 1'b0;
            end
            else if (do_pop)
            begin
                under_mem_reg <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            top_reg     <= top_next;
            m_tdata_reg <= {{PAD_W{1'b0}}, cnt_next, status, min_value, popped_value};
        end
        if (do_push)
        begin
            under_reg <= top_reg;
        end
    end

    // Stack memory: one write on a push that spills, one registered read on a pop.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cnt_m2[AW-1:0]] <= under_val;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[cnt_m3[AW-1:0]];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks on the stack bookkeeping.
    `ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= DEPTH_C, "stack count above depth")
    `ASSERT_NEXT(a_push_grows, do_push, cnt_reg == $past(cnt_reg) + ONE_C, "push did not grow stack")
    `ASSERT_NOW(a_full_occ, m_tvalid_reg && (m_tdata_reg[2*VW+1:2*VW] == mts_pkg::STATUS_FULL), m_tdata_reg[2*VW+2+CW-1:2*VW+2] == DEPTH_C, "full status below depth")
    `ASSERT_NOW(a_empty_min, m_tvalid_reg && (m_tdata_reg[2*VW+2+CW-1:2*VW+2] == '0), m_tdata_reg[2*VW-1:VW] == '1, "empty stack minimum not all ones")

endmodule
